@@ src/iso_tp_multi_slot_reassembler_macros.svh @@
// assertion macros for the iso-tp reassembler checker
// expects signals named clock and reset in the scope of use
`ifndef ISO_TP_MULTI_SLOT_REASSEMBLER_MACROS_SVH
`define ISO_TP_MULTI_SLOT_REASSEMBLER_MACROS_SVH

// next-cycle implication, masked while reset is high
`define ITPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itpr check failed");

// next-cycle implication, live through reset
`define ITPR_ASSERT_NEXT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("itpr check failed");

`endif

@@ src/itpr_pkg.sv @@
// types and constants shared by the iso-tp reassembler modules
// no dependencies
`timescale 1ns / 1ps

package itpr_pkg;

   localparam int ID_W   = 11;
   localparam int TIME_W = 32;
   localparam int BYTE_W = 8;
   localparam int DCNT_W = 3;
   localparam int LEN_W  = 12;
   localparam int SEQ_W  = 4;
   localparam int DATA_N = 7;
   localparam int TMO_W  = 16;

   localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd2000;

   localparam logic [3:0] PCI_SF = 4'h0;
   localparam logic [3:0] PCI_FF = 4'h1;
   localparam logic [3:0] PCI_CF = 4'h2;

   localparam logic [LEN_W-1:0]  FF_MIN_LEN = 12'd7;
   localparam logic [DCNT_W-1:0] FF_BYTES   = 3'd6;
   localparam logic [DCNT_W-1:0] FULL_DCNT  = 3'd7;
   localparam logic [SEQ_W-1:0]  FIRST_SEQ  = 4'd1;

   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   can_id;
      logic [TIME_W-1:0] now_ms;
      logic [7:0]        pci;
      logic [7:0]        data_0;
      logic [7:0]        data_1;
      logic [7:0]        data_2;
      logic [7:0]        data_3;
      logic [7:0]        data_4;
      logic [7:0]        data_5;
      logic [7:0]        data_6;
      logic [DCNT_W-1:0] data_count;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   msg_ident;
      logic [BYTE_W-1:0] msg_byte;
      logic [4:0]        byte_index;
      logic [5:0]        msg_length;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_SWEEP,
      OP_SF_GOOD,
      OP_SF_BAD,
      OP_FF_GOOD,
      OP_FF_BAD,
      OP_CF,
      OP_OTHER
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic [ID_W-1:0]               can_id;
      logic [TIME_W-1:0]             now_ms;
      logic [SEQ_W-1:0]              seq;
      logic [LEN_W-1:0]              total;
      logic [DATA_N-1:0][BYTE_W-1:0] data;
      logic [DCNT_W-1:0]             data_count;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIND,
      ST_PICK,
      ST_EXEC,
      ST_WRITE,
      ST_EMIT_REQ,
      ST_EMIT_PUSH,
      ST_SWEEP
   } state_type;

endpackage

@@ src/iso_tp_multi_slot_reassembler.sv @@
// top level of the iso-tp multi-slot reassembler
// depends on itpr_pkg, itpr_front, itpr_back and itpr_fifo
`timescale 1ns / 1ps

// Frames and timeout sweeps enter through a two-entry queue (req_push/req_full)
// and reassembled message bytes leave through a two-entry queue (rsp_pop/rsp_empty),
// one item per byte with last set on the final byte. Items are processed one at a
// time by a sequencer: it takes the item, scans the slot table for the matching,
// free or oldest slot, binds and decodes, then writes the bytes into the message
// buffer (six for a first frame, up to seven for a consecutive frame). A single
// frame emits one byte a cycle while the result queue is not full; a completed
// message is read back from the buffer one byte at a time, each through the
// registered buffer read. A sweep scans the slot table and evicts timed-out slots.
// The message buffer needs no clearing after reset. timeout_ms is written through
// csr_valid/csr_data, always ready, and should only change while the block is idle.
module iso_tp_multi_slot_reassembler #(
   parameter int SLOTS   = 8,
   parameter int MAX_MSG = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  itpr_pkg::req_type          req_item,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output itpr_pkg::rsp_type          rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [itpr_pkg::TMO_W-1:0] csr_data
);

   logic                                 job_valid, job_pop;
   itpr_pkg::job_type                    job;
   logic                                 out_push, out_full;
   itpr_pkg::rsp_type                    out_item;
   logic [$bits(itpr_pkg::rsp_type)-1:0] out_bits;

   itpr_front #(
      .MAX_MSG(MAX_MSG),
      .DEPTH  (2)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .job_valid(job_valid),
      .job_pop  (job_pop),
      .job      (job)
   );

   itpr_back #(
      .SLOTS  (SLOTS),
      .MAX_MSG(MAX_MSG)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data),
      .job_valid(job_valid),
      .job_pop  (job_pop),
      .job      (job),
      .rsp_push (out_push),
      .rsp_full (out_full),
      .rsp_item (out_item)
   );

   itpr_fifo #(
      .WIDTH($bits(itpr_pkg::rsp_type)),
      .DEPTH(2)
   ) u_rsp_q (
      .clock  (clock),
      .reset  (reset),
      .push   (out_push),
      .full   (out_full),
      .wr_data(out_item),
      .pop    (rsp_pop),
      .empty  (rsp_empty),
      .rd_data(out_bits)
   );

   assign rsp_item = itpr_pkg::rsp_type'(out_bits);

endmodule

@@ src/itpr_fifo.sv @@
// small synchronous queue with full and empty flags
// no dependencies
`timescale 1ns / 1ps

module itpr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ src/itpr_front.sv @@
// front end: takes frames and sweeps, classifies them, queues them for the back end
// depends on itpr_pkg and itpr_fifo
`timescale 1ns / 1ps

module itpr_front #(
   parameter int MAX_MSG = 32,
   parameter int DEPTH   = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  itpr_pkg::req_type req_item,
   output logic              job_valid,
   input  logic              job_pop,
   output itpr_pkg::job_type job
);

   itpr_pkg::job_type             job_in;
   logic [3:0]                    pci_type, pci_low;
   logic [itpr_pkg::LEN_W-1:0]    ff_total;
   logic                          job_empty;
   logic [$bits(itpr_pkg::job_type)-1:0] job_bits;

   assign pci_type = req_item.pci[7:4];
   assign pci_low  = req_item.pci[3:0];
   assign ff_total = {pci_low, req_item.data_0};

   always_comb begin
      job_in.can_id     = req_item.can_id;
      job_in.now_ms     = req_item.now_ms;
      job_in.seq        = pci_low;
      job_in.total      = ff_total;
      job_in.data       = {req_item.data_6, req_item.data_5, req_item.data_4,
                           req_item.data_3, req_item.data_2, req_item.data_1,
                           req_item.data_0};
      job_in.data_count = req_item.data_count;
      job_in.op         = itpr_pkg::OP_OTHER;
      if (req_item.kind) begin
         job_in.op = itpr_pkg::OP_SWEEP;
      end else begin
         unique case (pci_type)
            itpr_pkg::PCI_SF: begin
               job_in.total = itpr_pkg::LEN_W'(pci_low);
               if (pci_low >= 4'd1 && pci_low <= 4'd7 &&
                   4'(req_item.data_count) >= pci_low) begin
                  job_in.op = itpr_pkg::OP_SF_GOOD;
               end else begin
                  job_in.op = itpr_pkg::OP_SF_BAD;
               end
            end
            itpr_pkg::PCI_FF: begin
               if (ff_total >= itpr_pkg::FF_MIN_LEN &&
                   ff_total <= itpr_pkg::LEN_W'(MAX_MSG) &&
                   req_item.data_count == itpr_pkg::FULL_DCNT) begin
                  job_in.op = itpr_pkg::OP_FF_GOOD;
               end else begin
                  job_in.op = itpr_pkg::OP_FF_BAD;
               end
            end
            itpr_pkg::PCI_CF: begin
               job_in.op = itpr_pkg::OP_CF;
            end
            default: begin
               job_in.op = itpr_pkg::OP_OTHER;
            end
         endcase
      end
   end

   itpr_fifo #(
      .WIDTH($bits(itpr_pkg::job_type)),
      .DEPTH(DEPTH)
   ) u_job_q (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .full   (req_full),
      .wr_data(job_in),
      .pop    (job_pop),
      .empty  (job_empty),
      .rd_data(job_bits)
   );

   assign job_valid = !job_empty;
   assign job       = itpr_pkg::job_type'(job_bits);

endmodule

@@ src/itpr_back.sv @@
// back end: slot binding scan, slot table, message buffer and byte emission
// depends on itpr_pkg
`timescale 1ns / 1ps

module itpr_back #(
   parameter int SLOTS   = 8,
   parameter int MAX_MSG = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [itpr_pkg::TMO_W-1:0] csr_data,
   input  logic                       job_valid,
   output logic                       job_pop,
   input  itpr_pkg::job_type          job,
   output logic                       rsp_push,
   input  logic                       rsp_full,
   output itpr_pkg::rsp_type          rsp_item
);

   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MEM_DEPTH = SLOTS * MAX_MSG;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int LEN_W     = itpr_pkg::LEN_W;
   localparam int TIME_W    = itpr_pkg::TIME_W;
   localparam int ID_W      = itpr_pkg::ID_W;
   localparam int SEQ_W     = itpr_pkg::SEQ_W;

   // slot table
   logic [SLOTS-1:0]  valid_ff;
   logic [ID_W-1:0]   ident_ff [SLOTS];
   logic [LEN_W-1:0]  total_ff [SLOTS];
   logic [LEN_W-1:0]  count_ff [SLOTS];
   logic [SEQ_W-1:0]  seq_ff   [SLOTS];
   logic [TIME_W-1:0] start_ff [SLOTS];

   logic [7:0]        mem_ff [MEM_DEPTH];
   logic [7:0]        rd_data_ff;

   itpr_pkg::state_type state_ff, state_in;
   itpr_pkg::job_type   job_ff, job_in;

   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic              match_hit_ff, match_hit_in, free_hit_ff, free_hit_in;
   logic              old_hit_ff, old_hit_in;
   logic [SLOT_W-1:0] match_idx_ff, match_idx_in, free_idx_ff, free_idx_in;
   logic [SLOT_W-1:0] old_idx_ff, old_idx_in;
   logic [TIME_W-1:0] old_time_ff, old_time_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic [LEN_W-1:0]  wr_pos_ff, wr_pos_in;
   logic [2:0]        wr_n_ff, wr_n_in, wr_off_ff, wr_off_in;
   logic              done_ff, done_in;
   logic [LEN_W-1:0]  emit_len_ff, emit_len_in;
   logic              from_store_ff, from_store_in;
   logic [itpr_pkg::TMO_W-1:0] timeout_ff;

   // slot read port
   logic [SLOT_W-1:0] rd_idx;
   logic              rd_valid;
   logic [ID_W-1:0]   rd_ident;
   logic [LEN_W-1:0]  rd_total, rd_count;
   logic [SEQ_W-1:0]  rd_seq;
   logic [TIME_W-1:0] rd_start;

   // slot write controls
   logic              vld_we, vld_val, id_we, fld_we;
   logic [SLOT_W-1:0] vld_idx, id_idx, pick_idx;
   logic [LEN_W-1:0]  fld_total, fld_count;
   logic [SEQ_W-1:0]  fld_seq;
   logic [TIME_W-1:0] fld_start;

   logic              mem_we;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_byte;

   logic              scan_last, emit_last, write_more;
   logic [LEN_W-1:0]  remain;
   logic [2:0]        copy_n, wr_sel;
   logic              cf_seq_ok, cf_go, cf_done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= itpr_pkg::TIMEOUT_RST;
      end else if (csr_valid) begin
         timeout_ff <= csr_data;
      end
   end

   assign rd_idx   = (state_ff == itpr_pkg::ST_BIND || state_ff == itpr_pkg::ST_SWEEP) ?
                     scan_ff : slot_ff;
   assign rd_valid = valid_ff[rd_idx];
   assign rd_ident = ident_ff[rd_idx];
   assign rd_total = total_ff[rd_idx];
   assign rd_count = count_ff[rd_idx];
   assign rd_seq   = seq_ff[rd_idx];
   assign rd_start = start_ff[rd_idx];

   assign scan_last  = (scan_ff == SLOT_W'(SLOTS - 1));
   assign emit_last  = ((k_ff + LEN_W'(1)) == emit_len_ff);
   assign write_more = (k_ff < LEN_W'(wr_n_ff));
   assign pick_idx   = match_hit_ff ? match_idx_ff : (free_hit_ff ? free_idx_ff : old_idx_ff);

   assign remain    = rd_total - rd_count;
   assign copy_n    = (remain < LEN_W'(7)) ? remain[2:0] : 3'd7;
   assign cf_seq_ok = (job_ff.seq == rd_seq);
   assign cf_go     = rd_valid && cf_seq_ok && (job_ff.data_count >= copy_n);
   assign cf_done   = ((rd_count + LEN_W'(copy_n)) >= rd_total);

   assign wr_sel  = wr_off_ff + k_ff[2:0];
   assign wr_addr = base_ff + ADDR_W'(wr_pos_ff + k_ff);
   assign wr_byte = job_ff.data[wr_sel];
   assign rd_addr = base_ff + ADDR_W'(k_ff);

   always_comb begin
      rsp_item.msg_ident  = job_ff.can_id;
      rsp_item.msg_byte   = from_store_ff ? rd_data_ff : job_ff.data[k_ff[2:0]];
      rsp_item.byte_index = k_ff[4:0];
      rsp_item.msg_length = emit_len_ff[5:0];
      rsp_item.last       = emit_last;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itpr_pkg::ST_IDLE: begin
            if (job_valid) begin
               state_in = (job.op == itpr_pkg::OP_SWEEP) ? itpr_pkg::ST_SWEEP
                                                         : itpr_pkg::ST_BIND;
            end
         end
         itpr_pkg::ST_BIND: begin
            if (scan_last) begin
               state_in = itpr_pkg::ST_PICK;
            end
         end
         itpr_pkg::ST_PICK: begin
            state_in = itpr_pkg::ST_EXEC;
         end
         itpr_pkg::ST_EXEC: begin
            unique case (job_ff.op)
               itpr_pkg::OP_SF_GOOD: state_in = itpr_pkg::ST_EMIT_PUSH;
               itpr_pkg::OP_FF_GOOD: state_in = itpr_pkg::ST_WRITE;
               itpr_pkg::OP_CF:      state_in = cf_go ? itpr_pkg::ST_WRITE : itpr_pkg::ST_IDLE;
               default:              state_in = itpr_pkg::ST_IDLE;
            endcase
         end
         itpr_pkg::ST_WRITE: begin
            if (!write_more) begin
               state_in = done_ff ? itpr_pkg::ST_EMIT_REQ : itpr_pkg::ST_IDLE;
            end
         end
         itpr_pkg::ST_EMIT_REQ: begin
            state_in = itpr_pkg::ST_EMIT_PUSH;
         end
         itpr_pkg::ST_EMIT_PUSH: begin
            if (!rsp_full) begin
               if (emit_last) begin
                  state_in = itpr_pkg::ST_IDLE;
               end else if (from_store_ff) begin
                  state_in = itpr_pkg::ST_EMIT_REQ;
               end
            end
         end
         itpr_pkg::ST_SWEEP: begin
            if (scan_last) begin
               state_in = itpr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itpr_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and control outputs
   always_comb begin
      job_pop       = 1'b0;
      rsp_push      = 1'b0;
      job_in        = job_ff;
      scan_in       = scan_ff;
      match_hit_in  = match_hit_ff;
      match_idx_in  = match_idx_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      old_hit_in    = old_hit_ff;
      old_idx_in    = old_idx_ff;
      old_time_in   = old_time_ff;
      slot_in       = slot_ff;
      base_in       = base_ff;
      k_in          = k_ff;
      wr_pos_in     = wr_pos_ff;
      wr_n_in       = wr_n_ff;
      wr_off_in     = wr_off_ff;
      done_in       = done_ff;
      emit_len_in   = emit_len_ff;
      from_store_in = from_store_ff;
      vld_we        = 1'b0;
      vld_idx       = slot_ff;
      vld_val       = 1'b0;
      id_we         = 1'b0;
      id_idx        = pick_idx;
      fld_we        = 1'b0;
      fld_total     = rd_total;
      fld_count     = rd_count;
      fld_seq       = rd_seq;
      fld_start     = rd_start;
      mem_we        = 1'b0;
      unique case (state_ff)
         itpr_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_pop      = 1'b1;
               job_in       = job;
               scan_in      = '0;
               match_hit_in = 1'b0;
               free_hit_in  = 1'b0;
               old_hit_in   = 1'b0;
            end
         end
         itpr_pkg::ST_BIND: begin
            if (rd_valid) begin
               if (rd_ident == job_ff.can_id && !match_hit_ff) begin
                  match_hit_in = 1'b1;
                  match_idx_in = scan_ff;
               end
               if (!old_hit_ff || rd_start < old_time_ff) begin
                  old_hit_in  = 1'b1;
                  old_idx_in  = scan_ff;
                  old_time_in = rd_start;
               end
            end else if (!free_hit_ff) begin
               free_hit_in = 1'b1;
               free_idx_in = scan_ff;
            end
            scan_in = scan_ff + 1'b1;
         end
         itpr_pkg::ST_PICK: begin
            // no match and no free slot: evict the oldest
            if (!match_hit_ff && !free_hit_ff) begin
               vld_we  = 1'b1;
               vld_idx = old_idx_ff;
               vld_val = 1'b0;
            end
            id_we   = 1'b1;
            slot_in = pick_idx;
            base_in = ADDR_W'(pick_idx * MAX_MSG);
         end
         itpr_pkg::ST_EXEC: begin
            k_in = '0;
            case (job_ff.op)
               itpr_pkg::OP_SF_GOOD: begin
                  vld_we        = 1'b1;
                  emit_len_in   = job_ff.total;
                  from_store_in = 1'b0;
               end
               itpr_pkg::OP_SF_BAD, itpr_pkg::OP_FF_BAD: begin
                  vld_we = 1'b1;
               end
               itpr_pkg::OP_FF_GOOD: begin
                  vld_we    = 1'b1;
                  vld_val   = 1'b1;
                  fld_we    = 1'b1;
                  fld_total = job_ff.total;
                  fld_count = LEN_W'(itpr_pkg::FF_BYTES);
                  fld_seq   = itpr_pkg::FIRST_SEQ;
                  fld_start = job_ff.now_ms;
                  wr_pos_in = '0;
                  wr_n_in   = itpr_pkg::FF_BYTES;
                  wr_off_in = 3'd1;
                  done_in   = 1'b0;
               end
               itpr_pkg::OP_CF: begin
                  if (rd_valid && !cf_seq_ok) begin
                     vld_we = 1'b1;
                  end else if (cf_go) begin
                     vld_we        = 1'b1;
                     vld_val       = !cf_done;
                     fld_we        = 1'b1;
                     fld_count     = rd_count + LEN_W'(copy_n);
                     fld_seq       = job_ff.seq + 1'b1;
                     wr_pos_in     = rd_count;
                     wr_n_in       = copy_n;
                     wr_off_in     = 3'd0;
                     done_in       = cf_done;
                     emit_len_in   = rd_total;
                     from_store_in = 1'b1;
                  end
               end
               default: begin
                  vld_we = 1'b0;
               end
            endcase
         end
         itpr_pkg::ST_WRITE: begin
            if (write_more) begin
               mem_we = 1'b1;
               k_in   = k_ff + 1'b1;
            end else begin
               k_in = '0;
            end
         end
         itpr_pkg::ST_EMIT_REQ: begin
            k_in = k_ff;
         end
         itpr_pkg::ST_EMIT_PUSH: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               k_in     = k_ff + 1'b1;
            end
         end
         itpr_pkg::ST_SWEEP: begin
            if (rd_valid && (job_ff.now_ms - rd_start) > TIME_W'(timeout_ff)) begin
               vld_we  = 1'b1;
               vld_idx = scan_ff;
            end
            scan_in = scan_ff + 1'b1;
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itpr_pkg::ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (vld_we) begin
            valid_ff[vld_idx] <= vld_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         ident_ff[id_idx] <= job_ff.can_id;
      end
      if (fld_we) begin
         total_ff[slot_ff] <= fld_total;
         count_ff[slot_ff] <= fld_count;
         seq_ff[slot_ff]   <= fld_seq;
         start_ff[slot_ff] <= fld_start;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      scan_ff       <= scan_in;
      match_hit_ff  <= match_hit_in;
      match_idx_ff  <= match_idx_in;
      free_hit_ff   <= free_hit_in;
      free_idx_ff   <= free_idx_in;
      old_hit_ff    <= old_hit_in;
      old_idx_ff    <= old_idx_in;
      old_time_ff   <= old_time_in;
      slot_ff       <= slot_in;
      base_ff       <= base_in;
      k_ff          <= k_in;
      wr_pos_ff     <= wr_pos_in;
      wr_n_ff       <= wr_n_in;
      wr_off_ff     <= wr_off_in;
      done_ff       <= done_in;
      emit_len_ff   <= emit_len_in;
      from_store_ff <= from_store_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[wr_addr] <= wr_byte;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

@@ src/itpr_checker.sv @@
// port-level checks on the reassembler result queue
// depends on itpr_pkg and the macros header; bound to the top level below
`timescale 1ns / 1ps
`include "iso_tp_multi_slot_reassembler_macros.svh"

module itpr_port_checks (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input itpr_pkg::rsp_type rsp_item
);

   // a waiting item holds until taken
   `ITPR_ASSERT_NEXT(a_rsp_hold, (!rsp_empty && !rsp_pop), (!rsp_empty && $stable(rsp_item)))

   // bytes of one message follow each other without gaps
   `ITPR_ASSERT_NEXT(a_msg_contig, (!rsp_empty && rsp_pop && !rsp_item.last), (rsp_empty || (rsp_item.msg_ident == $past(rsp_item.msg_ident) && rsp_item.byte_index == $past(rsp_item.byte_index) + 5'd1 && rsp_item.msg_length == $past(rsp_item.msg_length))))

   // a new message starts at byte zero
   `ITPR_ASSERT_NEXT(a_msg_start, (!rsp_empty && rsp_pop && rsp_item.last), (rsp_empty || rsp_item.byte_index == 5'd0))

   // nothing is waiting right after reset
   `ITPR_ASSERT_NEXT_RST(a_reset_empty, reset, rsp_empty)

endmodule

bind iso_tp_multi_slot_reassembler itpr_port_checks u_itpr_checker (.*);
